@@ rtl/lcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// lcsr_pkg
// Types and constants shared by the LANCE-style CSR file: transfer payloads,
// opcodes, register selects and the CSR0 bit map.
// ----------------------------------------------------------------------------
package lcsr_pkg;

   typedef enum logic [2:0] {
      OP_READ_PTR     = 3'd0,
      OP_WRITE_PTR    = 3'd1,
      OP_READ_DATA    = 3'd2,
      OP_WRITE_DATA   = 3'd3,
      OP_RX_DONE      = 3'd4,
      OP_TX_DONE      = 3'd5,
      OP_RX_MISSED    = 3'd6,
      OP_TX_UNDERFLOW = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      SEL_CSR0 = 2'd0,
      SEL_CSR1 = 2'd1,
      SEL_CSR2 = 2'd2,
      SEL_CSR3 = 2'd3
   } csr_select_type;

   // configuration register indexes
   localparam logic CFG_DISABLE_TX = 1'b0;
   localparam logic CFG_DISABLE_RX = 1'b1;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        interrupt_line;
      logic        transmit_demand;
      logic        init_request;
      logic        byte_swap;
   } rsp_payload_type;

   // CSR0 bit positions
   localparam int ERR_BIT  = 15;
   localparam int BABL_BIT = 14;
   localparam int CERR_BIT = 13;
   localparam int MISS_BIT = 12;
   localparam int MERR_BIT = 11;
   localparam int RINT_BIT = 10;
   localparam int TINT_BIT = 9;
   localparam int IDON_BIT = 8;
   localparam int INTR_BIT = 7;
   localparam int INEA_BIT = 6;
   localparam int RXON_BIT = 5;
   localparam int TXON_BIT = 4;
   localparam int TDMD_BIT = 3;
   localparam int STOP_BIT = 2;
   localparam int STRT_BIT = 1;
   localparam int INIT_BIT = 0;

   // CSR0 masks
   localparam logic [15:0] CMD_SET_MASK   = 16'h000f; // INIT STRT STOP TDMD
   localparam logic [15:0] W1C_MASK       = 16'h7f00; // IDON .. BABL
   localparam logic [15:0] ERR_SRC_MASK   = 16'h7800; // BABL CERR MISS MERR
   localparam logic [15:0] INTR_SRC_MASK  = 16'h5f00; // BABL MISS MERR RINT TINT IDON
   localparam logic [15:0] STOP_STRT_INIT = 16'h0007;
   localparam logic [15:0] STRT_INIT_MASK = 16'h0003;
   localparam logic [15:0] STOP_ONLY      = 16'h0004;

   // other register masks
   localparam logic [15:0] CSR1_MASK = 16'hfffe;
   localparam logic [15:0] CSR2_MASK = 16'h00ff;

endpackage

@@ rtl/lance_control_status_registers_top.sv @@
// ----------------------------------------------------------------------------
// lance_control_status_registers_top
// CSR0..CSR3 register file of a LANCE-style Ethernet controller with a
// pointer/data port, engine event inputs and interrupt generation.
// ----------------------------------------------------------------------------
// One request transfer is taken per clock unless req_stall is high. Each
// request is either a bus access (read/write of the register pointer,
// read/write of the CSR that the pointer selects) or an event from the
// receive or transmit engine. The state update and the result are decided
// in the accepting cycle by a single level of logic on the CSR flops; the
// result lands in an output register, and throughput is one item per clock
// while the response is not stalled. A request is taken whenever the output
// register is empty or its content is being taken in the same cycle, i.e.
// req_stall only follows a stalled response. CSR0 reads show ERR as the OR
// of BABL, CERR, MISS and MERR; ERR is never stored. CSR1..CSR3 accept
// writes only while STOP is set. A stop edge forces CSR0 to STOP alone,
// clears CSR3 and drops the initialized state; the byte-swap output follows
// BSWP on each CSR3 data write. The mode bits (csr_ port, index 0 = disable
// transmitter, index 1 = disable receiver) must only be written while no
// transfer is in flight.
// ----------------------------------------------------------------------------
module lance_control_status_registers_top
   import lcsr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   // response channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   // mode register write port
   input  logic            csr_write_enable,
   input  logic            csr_index,
   input  logic            csr_write_data
);

   // mode bits
   logic disable_tx_ff, disable_tx_in;
   logic disable_rx_ff, disable_rx_in;

   // CSR state
   logic [15:0]    status_ff, status_in;
   logic [15:0]    addr_low_ff, addr_low_in;
   logic [7:0]     addr_high_ff, addr_high_in;
   logic [2:0]     bus_ctrl_ff, bus_ctrl_in;
   csr_select_type reg_select_ff, reg_select_in;
   logic           init_done_ff, init_done_in;
   logic           swap_ff, swap_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        req_accept;
   logic        stopped;
   logic [15:0] csr0_wr;   // CSR0 after a data write
   logic [15:0] rd_data;
   logic        tdmd_pulse;
   logic        init_pulse;

   // Output stage frees itself when the consumer takes the held result.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign stopped    = status_ff[STOP_BIT];

   // mode bit writes
   always_comb begin
      disable_tx_in = disable_tx_ff;
      disable_rx_in = disable_rx_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CFG_DISABLE_TX: disable_tx_in = csr_write_data;
            CFG_DISABLE_RX: disable_rx_in = csr_write_data;
            default:        disable_tx_in = disable_tx_ff;
         endcase
      end
   end

   // Main next-state and result logic.
   always_comb begin
      status_in     = status_ff;
      addr_low_in   = addr_low_ff;
      addr_high_in  = addr_high_ff;
      bus_ctrl_in   = bus_ctrl_ff;
      reg_select_in = reg_select_ff;
      init_done_in  = init_done_ff;
      swap_in       = swap_ff;
      rd_data       = '0;
      tdmd_pulse    = 1'b0;
      init_pulse    = 1'b0;
      csr0_wr       = status_ff;

      if (req_accept) begin
         unique case (req_payload.opcode)
            OP_READ_PTR: begin
               rd_data = {14'd0, reg_select_ff};
            end
            OP_WRITE_PTR: begin
               reg_select_in = csr_select_type'(req_payload.write_data[1:0]);
            end
            OP_READ_DATA: begin
               unique case (reg_select_ff)
                  SEL_CSR0: begin
                     rd_data          = status_ff;
                     rd_data[ERR_BIT] = |(status_ff & ERR_SRC_MASK);
                  end
                  SEL_CSR1: rd_data = addr_low_ff;
                  SEL_CSR2: rd_data = {8'd0, addr_high_ff};
                  SEL_CSR3: rd_data = {13'd0, bus_ctrl_ff};
                  default:  rd_data = '0;
               endcase
            end
            OP_WRITE_DATA: begin
               unique case (reg_select_ff)
                  SEL_CSR0: begin
                     // INEA direct, commands set, flags clear on one
                     csr0_wr[INEA_BIT] = req_payload.write_data[INEA_BIT];
                     csr0_wr = csr0_wr | (req_payload.write_data & CMD_SET_MASK);
                     csr0_wr = csr0_wr & ~(req_payload.write_data & W1C_MASK);
                     csr0_wr[ERR_BIT] = 1'b0;
                     // stop + start + init: only stop survives
                     if ((csr0_wr & STOP_STRT_INIT) == STOP_STRT_INIT) begin
                        csr0_wr = csr0_wr & ~STRT_INIT_MASK;
                     end
                     if (csr0_wr[INIT_BIT]) begin
                        csr0_wr[STOP_BIT] = 1'b0;
                     end
                     // start edge
                     if (csr0_wr[STRT_BIT] && !status_ff[STRT_BIT]) begin
                        csr0_wr[STOP_BIT] = 1'b0;
                        if (!disable_tx_ff) begin
                           csr0_wr[TXON_BIT] = 1'b1;
                        end
                        if (!disable_rx_ff) begin
                           csr0_wr[RXON_BIT] = 1'b1;
                        end
                     end
                     // stop edge
                     if (csr0_wr[STOP_BIT] && !status_ff[STOP_BIT]) begin
                        csr0_wr      = STOP_ONLY;
                        bus_ctrl_in  = '0;
                        init_done_in = 1'b0;
                     end
                     // init request
                     if (csr0_wr[INIT_BIT] && !init_done_in) begin
                        init_pulse        = 1'b1;
                        csr0_wr[IDON_BIT] = 1'b1;
                        init_done_in      = 1'b1;
                     end
                     // transmit demand
                     if (csr0_wr[STRT_BIT] && init_done_in && csr0_wr[TDMD_BIT]) begin
                        tdmd_pulse = 1'b1;
                     end
                     csr0_wr[TDMD_BIT] = 1'b0;
                     status_in = csr0_wr;
                  end
                  SEL_CSR1: begin
                     if (stopped) begin
                        addr_low_in = req_payload.write_data & CSR1_MASK;
                     end
                  end
                  SEL_CSR2: begin
                     if (stopped) begin
                        addr_high_in = req_payload.write_data[7:0];
                     end
                  end
                  SEL_CSR3: begin
                     if (stopped) begin
                        bus_ctrl_in = req_payload.write_data[2:0];
                     end
                     swap_in = bus_ctrl_in[2];
                  end
                  default: begin
                     status_in = status_ff;
                  end
               endcase
            end
            OP_RX_DONE: begin
               if (status_ff[RXON_BIT]) begin
                  status_in[RINT_BIT] = 1'b1;
               end
            end
            OP_TX_DONE: begin
               if (status_ff[TXON_BIT]) begin
                  status_in[TINT_BIT] = 1'b1;
               end
            end
            OP_RX_MISSED: begin
               if (status_ff[RXON_BIT]) begin
                  status_in[MISS_BIT] = 1'b1;
               end
            end
            OP_TX_UNDERFLOW: begin
               status_in[TXON_BIT] = 1'b0;
            end
            default: begin
               status_in = status_ff;
            end
         endcase
      end

      // INTR tracks the flag summary after every item
      status_in[INTR_BIT] = |(status_in & INTR_SRC_MASK);

      rsp_payload_in.read_data       = rd_data;
      rsp_payload_in.interrupt_line  = status_in[INTR_BIT] & status_in[INEA_BIT];
      rsp_payload_in.transmit_demand = tdmd_pulse;
      rsp_payload_in.init_request    = init_pulse;
      rsp_payload_in.byte_swap       = swap_in;
   end

   // Response held while stalled, refilled on each accepted request.
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         disable_tx_ff <= 1'b0;
         disable_rx_ff <= 1'b0;
         status_ff     <= '0;
         addr_low_ff   <= '0;
         addr_high_ff  <= '0;
         bus_ctrl_ff   <= '0;
         reg_select_ff <= SEL_CSR0;
         init_done_ff  <= 1'b0;
         swap_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         disable_tx_ff <= disable_tx_in;
         disable_rx_ff <= disable_rx_in;
         status_ff     <= status_in;
         addr_low_ff   <= addr_low_in;
         addr_high_ff  <= addr_high_in;
         bus_ctrl_ff   <= bus_ctrl_in;
         reg_select_ff <= reg_select_in;
         init_done_ff  <= init_done_in;
         swap_ff       <= swap_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   // STOP and STRT are mutually exclusive in the stored CSR0
   a_stop_strt_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(status_ff[STOP_BIT] && status_ff[STRT_BIT]))
      else $error("CSR0 holds STOP and STRT together");

   // stored INTR always equals the flag summary
   a_intr_summary: assert property (@(posedge clock) disable iff (reset)
      status_ff[INTR_BIT] == |(status_ff & INTR_SRC_MASK))
      else $error("CSR0 INTR out of step with its flags");

   // ERR and TDMD are never stored, CSR1 bit 0 stays clear
   a_transient_bits: assert property (@(posedge clock) disable iff (reset)
      !status_ff[ERR_BIT] && !status_ff[TDMD_BIT] && !addr_low_ff[0])
      else $error("transient or reserved bit stored");

   // an accepted request always yields a response next cycle
   a_accept_to_response: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // an init request leaves the block initialized
   a_init_sets_done: assert property (@(posedge clock) disable iff (reset)
      (req_accept && init_pulse) |=> (init_done_ff && status_ff[IDON_BIT]))
      else $error("init request did not mark the block initialized");
`endif

endmodule
